FILE: design/mcmf_pkg.sv
// Shared types, widths and codes of the min-cost max-flow engine.
package mcmf_pkg;

  localparam int MAX_NODES_DEF = 16;

  localparam int ACT_W      = 2;
  localparam int NODE_W     = 4;
  localparam int CAP_W      = 16;
  localparam int COST_W     = 12;
  localparam int TFLOW_W    = 24;
  localparam int TCOST_W    = 40;
  localparam int EFLOW_W    = 16;
  localparam int AUG_W      = 16;
  localparam int NCNT_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int DIST_W     = 24;
  localparam int ACC_W      = 50;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RUN   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_IDLE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_NODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK_NODE   = 2'd2;

  localparam logic [NCNT_W-1:0] NODE_COUNT_RST  = 5'd16;
  localparam logic [NODE_W-1:0] SOURCE_NODE_RST = 4'd0;
  localparam logic [NODE_W-1:0] SINK_NODE_RST   = 4'd15;

  localparam logic [TFLOW_W-1:0] FLOW_MAX = '1;
  localparam logic [TCOST_W-1:0] COST_MAX = '1;
  localparam logic [AUG_W-1:0]   AUG_MAX  = '1;

  typedef enum logic [3:0] {
    ST_RST_CLR,
    ST_IDLE,
    ST_RD_OUT,
    ST_FLOW_CLR,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_BF_RD,
    ST_BF_EV,
    ST_WK_START,
    ST_WK_PRED,
    ST_WK_EDGE,
    ST_WK_EV,
    ST_WK_ACC,
    ST_DONE
  } st_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_RST_CLR,
    OP_ITEM,
    OP_RD_OUT,
    OP_FLOW_CLR,
    OP_INIT_RD,
    OP_INIT_WR,
    OP_BF_RD,
    OP_BF_EV,
    OP_WK_START,
    OP_WK_PRED,
    OP_WK_EDGE,
    OP_WK_EV,
    OP_WK_ACC,
    OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic init_last;
    logic bf_last;
    logic bf_skip;
    logic term_bad;
    logic at_src;
    logic steps_over;
    logic pred_bad;
    logic arc_bad;
    logic pass2;
    logic bott_zero;
    logic out_free;
  } sts_t;

endpackage

FILE: design/mcmf_if.sv
// Request, result and configuration channel interfaces of the min-cost max-flow engine.
interface mcmf_in_if;
  logic                           valid;
  logic                           ready;
  logic [mcmf_pkg::ACT_W-1:0]     action;
  logic [mcmf_pkg::NODE_W-1:0]    from_node;
  logic [mcmf_pkg::NODE_W-1:0]    to_node;
  logic [mcmf_pkg::CAP_W-1:0]     capacity;
  logic [mcmf_pkg::COST_W-1:0]    unit_cost;
  modport source (output valid, action, from_node, to_node, capacity, unit_cost,
                  input ready);
  modport sink (input valid, action, from_node, to_node, capacity, unit_cost,
                output ready);
endinterface

interface mcmf_out_if;
  logic                           valid;
  logic                           ready;
  logic [mcmf_pkg::TFLOW_W-1:0]   total_flow;
  logic [mcmf_pkg::TCOST_W-1:0]   total_cost;
  logic [mcmf_pkg::EFLOW_W-1:0]   edge_flow;
  logic [mcmf_pkg::AUG_W-1:0]     augment_count;
  modport source (output valid, total_flow, total_cost, edge_flow, augment_count,
                  input ready);
  modport sink (input valid, total_flow, total_cost, edge_flow, augment_count,
                output ready);
endinterface

interface mcmf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mcmf_pkg::CFG_IDX_W-1:0]  index;
  logic [mcmf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/mcmf_ctrl.sv
// Controller state machine of the min-cost max-flow engine.
module mcmf_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [mcmf_pkg::ACT_W-1:0] in_action,
  output logic                       in_ready,
  output mcmf_pkg::cmd_t             cmd,
  input  mcmf_pkg::sts_t             sts
);
  import mcmf_pkg::*;

  st_t  st_r, st_nxt;
  logic accept;

  assign in_ready = (st_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RST_CLR;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_RST_CLR:  if (sts.clr_last) st_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_action == ACT_READ) st_nxt = ST_RD_OUT;
          else if (in_action == ACT_RUN) st_nxt = ST_FLOW_CLR;
        end
      end
      ST_RD_OUT:   if (sts.out_free) st_nxt = ST_IDLE;
      ST_FLOW_CLR: if (sts.clr_last) st_nxt = sts.term_bad ? ST_DONE : ST_INIT_RD;
      ST_INIT_RD:  st_nxt = ST_INIT_WR;
      ST_INIT_WR:  st_nxt = sts.init_last ? ST_BF_RD : ST_INIT_RD;
      ST_BF_RD: begin
        if (sts.bf_skip) st_nxt = sts.bf_last ? ST_WK_START : ST_BF_RD;
        else st_nxt = ST_BF_EV;
      end
      ST_BF_EV:    st_nxt = sts.bf_last ? ST_WK_START : ST_BF_RD;
      ST_WK_START: st_nxt = ST_WK_PRED;
      ST_WK_PRED: begin
        if (sts.at_src) begin
          // The first walk measures the bottleneck, the second applies it.
          if (sts.pass2) st_nxt = ST_INIT_RD;
          else if (sts.bott_zero) st_nxt = ST_DONE;
          else st_nxt = ST_WK_PRED;
        end else if (sts.steps_over) begin
          st_nxt = ST_DONE;
        end else begin
          st_nxt = ST_WK_EDGE;
        end
      end
      ST_WK_EDGE:  st_nxt = sts.pred_bad ? ST_DONE : ST_WK_EV;
      ST_WK_EV: begin
        if (sts.arc_bad) st_nxt = ST_DONE;
        else st_nxt = sts.pass2 ? ST_WK_ACC : ST_WK_PRED;
      end
      ST_WK_ACC:   st_nxt = ST_WK_PRED;
      ST_DONE:     if (sts.out_free) st_nxt = ST_IDLE;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NOP;
    unique case (st_r)
      ST_RST_CLR:  cmd.op = OP_RST_CLR;
      ST_IDLE:     cmd.op = accept ? OP_ITEM : OP_NOP;
      ST_RD_OUT:   cmd.op = OP_RD_OUT;
      ST_FLOW_CLR: cmd.op = OP_FLOW_CLR;
      ST_INIT_RD:  cmd.op = OP_INIT_RD;
      ST_INIT_WR:  cmd.op = OP_INIT_WR;
      ST_BF_RD:    cmd.op = OP_BF_RD;
      ST_BF_EV:    cmd.op = OP_BF_EV;
      ST_WK_START: cmd.op = OP_WK_START;
      ST_WK_PRED:  cmd.op = OP_WK_PRED;
      ST_WK_EDGE:  cmd.op = OP_WK_EDGE;
      ST_WK_EV:    cmd.op = OP_WK_EV;
      ST_WK_ACC:   cmd.op = OP_WK_ACC;
      ST_DONE:     cmd.op = OP_DONE;
      default:     cmd.op = OP_NOP;
    endcase
  end

endmodule

FILE: design/mcmf_dp.sv
// Datapath of the min-cost max-flow engine: edge memories, distances, walk and totals.
module mcmf_dp #(
  parameter int MAX_NODES = mcmf_pkg::MAX_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mcmf_pkg::cmd_t                  cmd,
  output mcmf_pkg::sts_t                  sts,
  input  logic [mcmf_pkg::ACT_W-1:0]      in_action,
  input  logic [mcmf_pkg::NODE_W-1:0]     in_from_node,
  input  logic [mcmf_pkg::NODE_W-1:0]     in_to_node,
  input  logic [mcmf_pkg::CAP_W-1:0]      in_capacity,
  input  logic [mcmf_pkg::COST_W-1:0]     in_unit_cost,
  input  logic                            cfg_valid,
  input  logic [mcmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcmf_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mcmf_pkg::TFLOW_W-1:0]    out_total_flow,
  output logic [mcmf_pkg::TCOST_W-1:0]    out_total_cost,
  output logic [mcmf_pkg::EFLOW_W-1:0]    out_edge_flow,
  output logic [mcmf_pkg::AUG_W-1:0]      out_augment_count
);
  import mcmf_pkg::*;

  localparam int IW    = $clog2(MAX_NODES);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam int NDEP  = 1 << IW;
  localparam int NW    = $clog2(MAX_NODES + 1);
  localparam int CCW   = CAP_W + COST_W;

  // Memories
  logic [CCW-1:0]    cc_mem   [DEPTH];
  logic [CAP_W-1:0]  fl_mem   [DEPTH];
  logic [DIST_W:0]   dist_mem [NDEP];
  logic [IW:0]       pred_mem [NDEP];

  logic [CCW-1:0]    cc_a_q, cc_b_q;
  logic [CAP_W-1:0]  fl_a_q, fl_b_q;
  logic [DIST_W:0]   dist_a_q, dist_b_q;
  logic [IW:0]       pred_q;

  // Control registers
  logic [NCNT_W-1:0]  nc_r, nc_nxt;
  logic [NODE_W-1:0]  src_r, src_nxt, snk_r, snk_nxt;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [IW-1:0]      i_r, i_nxt, u_r, u_nxt, k_r, k_nxt, j_r, j_nxt;
  logic [NW-1:0]      steps_r, steps_nxt;
  logic               pass2_r, pass2_nxt;
  logic [TFLOW_W-1:0] flow_acc_r, flow_acc_nxt;
  logic [ACC_W-1:0]   cost_acc_r, cost_acc_nxt;
  logic [AUG_W-1:0]   cnt_r, cnt_nxt;
  logic [TFLOW_W-1:0] tot_flow_r, tot_flow_nxt;
  logic [TCOST_W-1:0] tot_cost_r, tot_cost_nxt;
  logic [AUG_W-1:0]   aug_r, aug_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               item_ok_r, item_ok_nxt;

  // Payload registers
  logic [CAP_W:0]     least_r, least_nxt;
  logic [CAP_W-1:0]   bott_r, bott_nxt;
  logic [CCW-1:0]     prod_r, prod_nxt;
  logic               prod_neg_r, prod_neg_nxt;
  logic [AW-1:0]      addr_a_r, addr_b_r;
  logic [TFLOW_W-1:0] out_flow_r, out_flow_nxt;
  logic [TCOST_W-1:0] out_cost_r, out_cost_nxt;
  logic [EFLOW_W-1:0] out_edge_r, out_edge_nxt;
  logic [AUG_W-1:0]   out_aug_r, out_aug_nxt;

  // Combinational
  logic [NW-1:0]      n_w, nm1;
  logic [IW-1:0]      s_idx, t_idx, from_idx, to_idx, pidx;
  logic               pok, item_ok;
  logic               i_last, u_last, k_last;
  logic               rd_en, dist_rd_en, pred_rd_en;
  logic [AW-1:0]      addr_a, addr_b;
  logic               cc_we, fl_we, dist_we;
  logic [AW-1:0]      cc_wa, fl_wa;
  logic [CCW-1:0]     cc_wd;
  logic [CAP_W-1:0]   fl_wd;
  logic [IW-1:0]      dist_wa;
  logic [DIST_W:0]    dist_wd;
  logic [IW:0]        pred_wd;
  logic [CAP_W-1:0]   cap_a, cap_b, fl_a, fl_b, room;
  logic [COST_W-1:0]  cost_a, cost_b;
  logic               fwd, bk, arc_ok;
  logic [DIST_W-1:0]  arc_w, cand;
  logic               relax, out_free;
  logic [TFLOW_W:0]   flow_sum;

  assign s_idx    = IW'(src_r);
  assign t_idx    = IW'(snk_r);
  assign from_idx = IW'(in_from_node);
  assign to_idx   = IW'(in_to_node);
  assign item_ok  = (32'(in_from_node) < MAX_NODES) && (32'(in_to_node) < MAX_NODES);
  assign pidx     = pred_q[IW-1:0];
  assign pok      = pred_q[IW];

  always_comb begin
    if (32'(nc_r) < 2) n_w = NW'(2);
    else if (32'(nc_r) > MAX_NODES) n_w = NW'(MAX_NODES);
    else n_w = NW'(nc_r);
  end
  assign nm1    = n_w - NW'(1);
  assign i_last = (NW'(i_r) == nm1);
  assign u_last = (NW'(u_r) == nm1);
  assign k_last = (NW'(k_r) == nm1);

  // Residual arc for the pair held in port A as (x,y), port B as (y,x).
  // A reverse arc always costs no more than the forward one, so it wins.
  assign cap_a  = cc_a_q[CCW-1:COST_W];
  assign cost_a = cc_a_q[COST_W-1:0];
  assign cap_b  = cc_b_q[CCW-1:COST_W];
  assign cost_b = cc_b_q[COST_W-1:0];
  assign fl_a   = fl_a_q;
  assign fl_b   = fl_b_q;
  assign fwd    = (cap_a != '0) && (fl_a < cap_a);
  assign bk     = (cap_b != '0) && (fl_b != '0);
  assign arc_ok = (addr_a_r[AW-1:IW] != addr_a_r[IW-1:0]) && (fwd || bk);
  assign arc_w  = bk ? (DIST_W'(0) - DIST_W'(cost_b)) : DIST_W'(cost_a);
  assign room   = bk ? fl_b : (cap_a - fl_a);
  assign cand   = dist_a_q[DIST_W-1:0] + arc_w;
  assign relax  = arc_ok && dist_a_q[DIST_W] &&
                  (!dist_b_q[DIST_W] || ($signed(dist_b_q[DIST_W-1:0]) > $signed(cand)));
  assign out_free = !out_valid_r || out_ready;
  assign flow_sum = {1'b0, flow_acc_r} + (TFLOW_W+1)'(bott_r);

  // Status
  always_comb begin
    sts.clr_last   = (clr_cnt_r == AW'(DEPTH - 1));
    sts.init_last  = i_last;
    sts.bf_last    = k_last && u_last && i_last;
    sts.bf_skip    = (u_r == s_idx) || (i_r == u_r);
    sts.term_bad   = (32'(src_r) >= 32'(n_w)) || (32'(snk_r) >= 32'(n_w)) || (src_r == snk_r);
    sts.at_src     = (j_r == s_idx);
    sts.steps_over = (steps_r >= n_w);
    sts.pred_bad   = !pok || (32'(pidx) >= 32'(n_w));
    sts.arc_bad    = !arc_ok;
    sts.pass2      = pass2_r;
    sts.bott_zero  = (least_r == '0) || least_r[CAP_W];
    sts.out_free   = out_free;
  end

  // Memory port addressing
  always_comb begin
    rd_en      = 1'b0;
    dist_rd_en = 1'b0;
    pred_rd_en = 1'b0;
    addr_a     = {from_idx, to_idx};
    addr_b     = {to_idx, from_idx};
    unique case (cmd.op)
      OP_ITEM:    rd_en = (in_action == ACT_READ);
      OP_INIT_RD: begin
        rd_en  = 1'b1;
        addr_a = {s_idx, i_r};
        addr_b = {i_r, s_idx};
      end
      OP_BF_RD: begin
        rd_en      = !sts.bf_skip;
        dist_rd_en = !sts.bf_skip;
        addr_a     = {i_r, u_r};
        addr_b     = {u_r, i_r};
      end
      OP_WK_PRED: pred_rd_en = !sts.at_src && !sts.steps_over;
      OP_WK_EDGE: begin
        rd_en  = !sts.pred_bad;
        addr_a = {pidx, j_r};
        addr_b = {j_r, pidx};
      end
      default: ;
    endcase
  end

  always_comb begin
    cc_we   = 1'b0;
    cc_wa   = {from_idx, to_idx};
    cc_wd   = {in_capacity, in_unit_cost};
    fl_we   = 1'b0;
    fl_wa   = clr_cnt_r;
    fl_wd   = '0;
    dist_we = 1'b0;
    dist_wa = i_r;
    dist_wd = '0;
    pred_wd = '0;
    unique case (cmd.op)
      OP_RST_CLR: begin
        cc_we = 1'b1;
        cc_wa = clr_cnt_r;
        cc_wd = '0;
        fl_we = 1'b1;
      end
      OP_FLOW_CLR: fl_we = 1'b1;
      OP_ITEM:     cc_we = (in_action == ACT_WRITE) && item_ok;
      OP_INIT_WR: begin
        dist_we = 1'b1;
        dist_wa = i_r;
        dist_wd = {(i_r == s_idx) || arc_ok, (i_r == s_idx) ? DIST_W'(0) : arc_w};
        pred_wd = {(i_r != s_idx) && arc_ok, s_idx};
      end
      OP_BF_EV: begin
        dist_we = relax;
        dist_wa = u_r;
        dist_wd = {1'b1, cand};
        pred_wd = {1'b1, i_r};
      end
      OP_WK_EV: begin
        fl_we = pass2_r && arc_ok;
        fl_wa = bk ? addr_b_r : addr_a_r;
        fl_wd = bk ? (fl_b - bott_r) : (fl_a + bott_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cc_we) cc_mem[cc_wa] <= cc_wd;
    if (fl_we) fl_mem[fl_wa] <= fl_wd;
    if (rd_en) begin
      cc_a_q   <= cc_mem[addr_a];
      cc_b_q   <= cc_mem[addr_b];
      fl_a_q   <= fl_mem[addr_a];
      fl_b_q   <= fl_mem[addr_b];
      addr_a_r <= addr_a;
      addr_b_r <= addr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
      pred_mem[dist_wa] <= pred_wd;
    end
    if (dist_rd_en) begin
      dist_a_q <= dist_mem[i_r];
      dist_b_q <= dist_mem[u_r];
    end
    if (pred_rd_en) pred_q <= pred_mem[j_r];
  end

  // Sequencing of counters, accumulators and the result register
  always_comb begin
    nc_nxt        = nc_r;
    src_nxt       = src_r;
    snk_nxt       = snk_r;
    clr_cnt_nxt   = clr_cnt_r;
    i_nxt         = i_r;
    u_nxt         = u_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    steps_nxt     = steps_r;
    pass2_nxt     = pass2_r;
    flow_acc_nxt  = flow_acc_r;
    cost_acc_nxt  = cost_acc_r;
    cnt_nxt       = cnt_r;
    tot_flow_nxt  = tot_flow_r;
    tot_cost_nxt  = tot_cost_r;
    aug_nxt       = aug_r;
    item_ok_nxt   = item_ok_r;
    least_nxt     = least_r;
    bott_nxt      = bott_r;
    prod_nxt      = prod_r;
    prod_neg_nxt  = prod_neg_r;
    out_flow_nxt  = out_flow_r;
    out_cost_nxt  = out_cost_r;
    out_edge_nxt  = out_edge_r;
    out_aug_nxt   = out_aug_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NODE_COUNT:  nc_nxt  = cfg_data[NCNT_W-1:0];
        CFG_SOURCE_NODE: src_nxt = cfg_data[NODE_W-1:0];
        CFG_SINK_NODE:   snk_nxt = cfg_data[NODE_W-1:0];
        default: ;
      endcase
    end

    unique case (cmd.op)
      OP_RST_CLR, OP_FLOW_CLR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        i_nxt       = '0;
      end
      OP_ITEM: begin
        item_ok_nxt = item_ok;
        if (in_action == ACT_RUN) begin
          clr_cnt_nxt  = '0;
          flow_acc_nxt = '0;
          cost_acc_nxt = '0;
          cnt_nxt      = '0;
        end
      end
      OP_RD_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_flow_nxt  = tot_flow_r;
          out_cost_nxt  = tot_cost_r;
          out_aug_nxt   = aug_r;
          out_edge_nxt  = item_ok_r ? fl_a_q : '0;
        end
      end
      OP_INIT_WR: begin
        if (i_last) begin
          i_nxt = '0;
          u_nxt = '0;
          k_nxt = IW'(1);
        end else begin
          i_nxt = i_r + IW'(1);
        end
      end
      OP_BF_RD, OP_BF_EV: begin
        if (cmd.op == OP_BF_EV || sts.bf_skip) begin
          if (i_last) begin
            i_nxt = '0;
            if (u_last) begin
              u_nxt = '0;
              k_nxt = k_r + IW'(1);
            end else begin
              u_nxt = u_r + IW'(1);
            end
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end
      end
      OP_WK_START: begin
        j_nxt     = t_idx;
        steps_nxt = '0;
        least_nxt = {1'b1, {CAP_W{1'b0}}};
        pass2_nxt = 1'b0;
      end
      OP_WK_PRED: begin
        if (sts.at_src) begin
          if (pass2_r) begin
            flow_acc_nxt = flow_sum[TFLOW_W] ? FLOW_MAX : flow_sum[TFLOW_W-1:0];
            if (cnt_r != AUG_MAX) cnt_nxt = cnt_r + AUG_W'(1);
            pass2_nxt = 1'b0;
            i_nxt     = '0;
          end else if (!sts.bott_zero) begin
            bott_nxt  = least_r[CAP_W-1:0];
            pass2_nxt = 1'b1;
            j_nxt     = t_idx;
            steps_nxt = '0;
          end
        end
      end
      OP_WK_EV: begin
        if (arc_ok) begin
          if ({1'b0, room} < least_r) least_nxt = {1'b0, room};
          prod_nxt     = CCW'(bott_r) * CCW'(bk ? cost_b : cost_a);
          prod_neg_nxt = bk;
          j_nxt        = addr_a_r[AW-1:IW];
          steps_nxt    = steps_r + NW'(1);
        end
      end
      OP_WK_ACC: begin
        cost_acc_nxt = prod_neg_r ? (cost_acc_r - ACC_W'(prod_r))
                                  : (cost_acc_r + ACC_W'(prod_r));
      end
      OP_DONE: begin
        if (out_free) begin
          tot_flow_nxt = flow_acc_r;
          if (cost_acc_r[ACC_W-1]) tot_cost_nxt = '0;
          else if (|cost_acc_r[ACC_W-2:TCOST_W]) tot_cost_nxt = COST_MAX;
          else tot_cost_nxt = cost_acc_r[TCOST_W-1:0];
          aug_nxt       = cnt_r;
          out_valid_nxt = 1'b1;
          out_flow_nxt  = tot_flow_nxt;
          out_cost_nxt  = tot_cost_nxt;
          out_aug_nxt   = cnt_r;
          out_edge_nxt  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r        <= NODE_COUNT_RST;
      src_r       <= SOURCE_NODE_RST;
      snk_r       <= SINK_NODE_RST;
      clr_cnt_r   <= '0;
      i_r         <= '0;
      u_r         <= '0;
      k_r         <= '0;
      j_r         <= '0;
      steps_r     <= '0;
      pass2_r     <= 1'b0;
      flow_acc_r  <= '0;
      cost_acc_r  <= '0;
      cnt_r       <= '0;
      tot_flow_r  <= '0;
      tot_cost_r  <= '0;
      aug_r       <= '0;
      out_valid_r <= 1'b0;
      item_ok_r   <= 1'b0;
    end else begin
      nc_r        <= nc_nxt;
      src_r       <= src_nxt;
      snk_r       <= snk_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      i_r         <= i_nxt;
      u_r         <= u_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      steps_r     <= steps_nxt;
      pass2_r     <= pass2_nxt;
      flow_acc_r  <= flow_acc_nxt;
      cost_acc_r  <= cost_acc_nxt;
      cnt_r       <= cnt_nxt;
      tot_flow_r  <= tot_flow_nxt;
      tot_cost_r  <= tot_cost_nxt;
      aug_r       <= aug_nxt;
      out_valid_r <= out_valid_nxt;
      item_ok_r   <= item_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    least_r    <= least_nxt;
    bott_r     <= bott_nxt;
    prod_r     <= prod_nxt;
    prod_neg_r <= prod_neg_nxt;
    out_flow_r <= out_flow_nxt;
    out_cost_r <= out_cost_nxt;
    out_edge_r <= out_edge_nxt;
    out_aug_r  <= out_aug_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_total_flow    = out_flow_r;
  assign out_total_cost    = out_cost_r;
  assign out_edge_flow     = out_edge_r;
  assign out_augment_count = out_aug_r;

endmodule

FILE: design/min_cost_max_flow_engine.sv
// Top level of the min-cost max-flow engine.
// An edge write gives no result; an edge flow read looks up the pair and then
// registers its result once the output register is free. A run first clears
// the flow memory, then per augmenting path seeds the distances from the
// source, relaxes (n-1) rounds of n*n node pairs in the Bellman-Ford loop,
// with one pair lookup from the memory ports per relaxation, and makes two
// walks along the path, the first to measure the bottleneck and the second
// to apply it.
// After reset a clearing pass runs through the edge memories before the first
// request is taken. The configuration port is always ready; the user must write
// it only while no request is in flight, and the block itself does not enforce this.
module min_cost_max_flow_engine #(
  parameter int MAX_NODES = mcmf_pkg::MAX_NODES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mcmf_in_if.sink    in_ch,
  mcmf_out_if.source out_ch,
  mcmf_cfg_if.sink   cfg_ch
);
  import mcmf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  mcmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mcmf_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_action         (in_ch.action),
    .in_from_node      (in_ch.from_node),
    .in_to_node        (in_ch.to_node),
    .in_capacity       (in_ch.capacity),
    .in_unit_cost      (in_ch.unit_cost),
    .cfg_valid         (cfg_ch.valid),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_total_flow    (out_ch.total_flow),
    .out_total_cost    (out_ch.total_cost),
    .out_edge_flow     (out_ch.edge_flow),
    .out_augment_count (out_ch.augment_count)
  );

endmodule

FILE: design/mcmf_checker.sv
// Port-level assertions of the min-cost max-flow engine and their bind.
module mcmf_props (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [mcmf_pkg::ACT_W-1:0] in_action,
  input logic                       out_valid,
  input logic                       out_ready
);
  import mcmf_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_action == ACT_WRITE) && !out_valid |=> !out_valid)
    else $error("edge write produced a result");

  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_action == ACT_READ) && !out_valid |-> ##2 out_valid)
    else $error("edge read result late");

  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_action == ACT_RUN) |=> !in_ready)
    else $error("request taken during a run");

endmodule

bind min_cost_max_flow_engine mcmf_props u_mcmf_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

FILE: test/mcmf_checker.sv
// Checker of the min-cost max-flow engine: predicts every result and compares it.
module mcmf_checker (
  input  logic clk,
  input  logic rst_n,
  mcmf_in_if   in_ch,
  mcmf_out_if  out_ch,
  mcmf_cfg_if  cfg_ch,
  output int   errors,
  output int   pending
);
  import mcmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NN = MAX_NODES_DEF;

  typedef struct {
    logic [TFLOW_W-1:0] total_flow;
    logic [TCOST_W-1:0] total_cost;
    logic [EFLOW_W-1:0] edge_flow;
    logic [AUG_W-1:0]   augment_count;
  } flow_result_t;

  flow_result_t result_fifo[$];

  logic [NCNT_W-1:0] node_cnt;
  logic [NODE_W-1:0] src_sel, snk_sel;
  logic [CAP_W-1:0]  cap_mem[NN][NN];
  logic [COST_W-1:0] cost_mem[NN][NN];
  logic [CAP_W-1:0]  flow_mem[NN][NN];
  int                arc_w[NN][NN];
  bit                arc_live[NN][NN], arc_rev[NN][NN];
  int                dist_val[NN], prev_node[NN];
  bit                dist_live[NN], prev_live[NN];
  logic [TFLOW_W-1:0] last_flow;
  logic [TCOST_W-1:0] last_cost;
  logic [AUG_W-1:0]   last_aug;
  longint            path_cost;

  assign pending = result_fifo.size();

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic build_residual_arcs(input int n);
    int w;
    bit ok, back;
    for (int u = 0; u < n; u++)
      for (int v = 0; v < n; v++) begin
        ok = 0; back = 0; w = 0;
        if (u != v) begin
          if (cap_mem[u][v] != 0 && flow_mem[u][v] < cap_mem[u][v]) begin
            w = int'(cost_mem[u][v]);
            ok = 1;
          end
          // Reverse arc wins over the forward one on a cost tie.
          if (cap_mem[v][u] != 0 && flow_mem[v][u] > 0) begin
            if (!ok || -int'(cost_mem[v][u]) <= w) begin
              w = -int'(cost_mem[v][u]);
              back = 1;
              ok = 1;
            end
          end
        end
        arc_w[u][v] = w;
        arc_live[u][v] = ok;
        arc_rev[u][v] = back;
      end
  endtask

  task automatic relax_paths(input int n, input int s);
    int cand;
    for (int i = 0; i < n; i++) begin
      dist_live[i] = (i == s) || arc_live[s][i];
      dist_val[i] = (i == s) ? 0 : arc_w[s][i];
      prev_live[i] = (i != s) && arc_live[s][i];
      prev_node[i] = s;
    end
    for (int k = 1; k < n; k++)
      for (int u = 0; u < n; u++) begin
        if (u == s) continue;
        for (int i = 0; i < n; i++) begin
          if (i == u || !arc_live[i][u] || !dist_live[i]) continue;
          cand = dist_val[i] + arc_w[i][u];
          if (!dist_live[u] || dist_val[u] > cand) begin
            dist_val[u] = cand;
            dist_live[u] = 1;
            prev_node[u] = i;
            prev_live[u] = 1;
          end
        end
      end
  endtask

  // With amount zero only the bottleneck is found; otherwise the path is augmented.
  task automatic trace_path(input int n, input int s, input int t, input int amount,
                            output int least);
    int j, steps, i, room;
    j = t; steps = 0; least = 65536;
    while (j != s) begin
      if (steps >= n || !prev_live[j]) begin
        least = 0;
        return;
      end
      i = prev_node[j];
      if (i >= n || !arc_live[i][j]) begin
        least = 0;
        return;
      end
      if (arc_rev[i][j]) begin
        room = int'(flow_mem[j][i]);
        if (amount != 0) begin
          flow_mem[j][i] = CAP_W'(int'(flow_mem[j][i]) - amount);
          path_cost -= longint'(amount) * longint'(cost_mem[j][i]);
        end
      end else begin
        room = int'(cap_mem[i][j]) - int'(flow_mem[i][j]);
        if (amount != 0) begin
          flow_mem[i][j] = CAP_W'(int'(flow_mem[i][j]) + amount);
          path_cost += longint'(amount) * longint'(cost_mem[i][j]);
        end
      end
      if (room < least) least = room;
      j = i;
      steps++;
    end
    if (steps == 0) least = 0;
  endtask

  task automatic solve_flow();
    int n, s, t, cnt, neck, dummy;
    longint flow;
    n = int'(node_cnt); s = int'(src_sel); t = int'(snk_sel);
    cnt = 0; flow = 0; path_cost = 0;
    if (n < 2) n = 2;
    if (n > NN) n = NN;
    for (int u = 0; u < NN; u++)
      for (int v = 0; v < NN; v++) flow_mem[u][v] = '0;
    if (s < n && t < n && s != t) begin
      forever begin
        build_residual_arcs(n);
        relax_paths(n, s);
        if (!prev_live[t]) break;
        trace_path(n, s, t, 0, neck);
        if (neck == 0) break;
        trace_path(n, s, t, neck, dummy);
        flow += neck;
        if (cnt < 65535) cnt++;
      end
    end
    last_flow = (flow > longint'(FLOW_MAX)) ? FLOW_MAX : flow[TFLOW_W-1:0];
    if (path_cost < 0) path_cost = 0;
    last_cost = (path_cost > longint'(COST_MAX)) ? COST_MAX : path_cost[TCOST_W-1:0];
    last_aug = cnt[AUG_W-1:0];
  endtask

  always @(posedge clk) begin
    flow_result_t r, e;
    if (!rst_n) begin
      node_cnt <= NODE_COUNT_RST;
      src_sel  <= SOURCE_NODE_RST;
      snk_sel  <= SINK_NODE_RST;
      for (int u = 0; u < NN; u++)
        for (int v = 0; v < NN; v++) begin
          cap_mem[u][v] = '0;
          cost_mem[u][v] = '0;
          flow_mem[u][v] = '0;
        end
      last_flow = '0; last_cost = '0; last_aug = '0;
      result_fifo.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_NODE_COUNT:  node_cnt <= cfg_ch.data[NCNT_W-1:0];
          CFG_SOURCE_NODE: src_sel  <= cfg_ch.data[NODE_W-1:0];
          CFG_SINK_NODE:   snk_sel  <= cfg_ch.data[NODE_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        r.total_flow = out_ch.total_flow;
        r.total_cost = out_ch.total_cost;
        r.edge_flow = out_ch.edge_flow;
        r.augment_count = out_ch.augment_count;
        if (result_fifo.size() == 0) begin
          report("result with no request waiting");
        end else begin
          e = result_fifo.pop_front();
          if (r.total_flow !== e.total_flow)
            report($sformatf("total_flow %0d, wanted %0d", r.total_flow, e.total_flow));
          if (r.total_cost !== e.total_cost)
            report($sformatf("total_cost %0d, wanted %0d", r.total_cost, e.total_cost));
          if (r.edge_flow !== e.edge_flow)
            report($sformatf("edge_flow %0d, wanted %0d", r.edge_flow, e.edge_flow));
          if (r.augment_count !== e.augment_count)
            report($sformatf("augment_count %0d, wanted %0d", r.augment_count,
                             e.augment_count));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.action)
          ACT_WRITE: begin
            cap_mem[in_ch.from_node][in_ch.to_node] = in_ch.capacity;
            cost_mem[in_ch.from_node][in_ch.to_node] = in_ch.unit_cost;
          end
          ACT_RUN, ACT_READ: begin
            if (in_ch.action == ACT_RUN) solve_flow();
            e.total_flow = last_flow;
            e.total_cost = last_cost;
            e.edge_flow = (in_ch.action == ACT_READ) ?
                          flow_mem[in_ch.from_node][in_ch.to_node] : '0;
            e.augment_count = last_aug;
            result_fifo.push_back(e);
          end
          default: ;
        endcase
      end
    end
  end

  initial errors = 0;
endmodule

FILE: test/min_cost_max_flow_engine_tb.sv
// Stimulus and verdict of the min-cost max-flow engine testbench.
module min_cost_max_flow_engine_tb;
  import mcmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst_n = 0;
  int   errors, pending;
  bit   calm = 0;
  bit   hold_req = 0;
  int   nodes_now = 16;

  mcmf_in_if  in_ch();
  mcmf_out_if out_ch();
  mcmf_cfg_if cfg_ch();

  min_cost_max_flow_engine uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  mcmf_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .errors(errors), .pending(pending)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    #2_000_000_000;
    $display("[min_cost_max_flow_engine] ERROR");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = 300;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 0;
      end else begin
        out_ch.ready = calm || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  function automatic int nodes_now_of(input int n);
    return (n < 2) ? 2 : (n > 16) ? 16 : n;
  endfunction

  task automatic send_request(input logic [ACT_W-1:0] act, input int f, input int t,
                              input int cap, input int cst);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_ch.valid = 0;
      @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.action = act;
    in_ch.from_node = f[NODE_W-1:0];
    in_ch.to_node = t[NODE_W-1:0];
    in_ch.capacity = cap[CAP_W-1:0];
    in_ch.unit_cost = cst[COST_W-1:0];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    drain();
    cfg_ch.valid = 1;
    cfg_ch.index = idx;
    cfg_ch.data = val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 0;
  endtask

  task automatic set_graph(input int n, input int s, input int t);
    write_reg(CFG_NODE_COUNT, n);
    write_reg(CFG_SOURCE_NODE, s);
    write_reg(CFG_SINK_NODE, t);
    nodes_now = nodes_now_of(n);
  endtask

  task automatic random_phase(input int count);
    int r, f, t, cap, n;
    n = nodes_now;
    repeat (count) begin
      r = $urandom_range(0, 99);
      f = $urandom_range(0, n - 1);
      t = $urandom_range(0, n - 1);
      cap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 20);
      if (r < 66) begin
        if ($urandom_range(0, 9) == 0) begin
          f = $urandom_range(0, 15);
          t = $urandom_range(0, 15);
        end
        send_request(ACT_WRITE, f, t, cap, $urandom_range(0, 4095));
      end else if (r < 88) begin
        send_request(ACT_READ, $urandom_range(0, 15), $urandom_range(0, 15), 0, 0);
      end else if (r < ((n > 8) ? 90 : 95)) begin
        send_request(ACT_RUN, f, t, cap, $urandom_range(0, 4095));
      end else begin
        send_request(ACT_IDLE, f, t, cap, $urandom_range(0, 4095));
      end
    end
  endtask

  initial begin
    int n;
    in_ch.valid = 0;
    in_ch.action = ACT_WRITE;
    in_ch.from_node = '0;
    in_ch.to_node = '0;
    in_ch.capacity = '0;
    in_ch.unit_cost = '0;
    cfg_ch.valid = 0;
    cfg_ch.index = CFG_NODE_COUNT;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: a small graph with antiparallel edges, a self loop and extremes.
    set_graph(4, 0, 3);
    send_request(ACT_WRITE, 0, 1, 65535, 4095);
    send_request(ACT_WRITE, 0, 2, 5, 1);
    send_request(ACT_WRITE, 1, 2, 7, 0);
    send_request(ACT_WRITE, 2, 1, 3, 2);
    send_request(ACT_WRITE, 1, 3, 6, 3);
    send_request(ACT_WRITE, 2, 3, 4, 1);
    send_request(ACT_WRITE, 2, 2, 9, 5);
    send_request(ACT_WRITE, 0, 9, 8, 1);
    send_request(ACT_IDLE, 15, 15, 65535, 4095);
    send_request(ACT_RUN, 0, 0, 0, 0);
    send_request(ACT_READ, 0, 1, 0, 0);
    send_request(ACT_READ, 2, 2, 0, 0);
    send_request(ACT_READ, 0, 9, 0, 0);
    send_request(ACT_WRITE, 0, 1, 0, 0);
    send_request(ACT_READ, 0, 1, 0, 0);
    send_request(ACT_RUN, 0, 0, 0, 0);
    send_request(ACT_READ, 15, 15, 0, 0);
    set_graph(4, 2, 2);
    send_request(ACT_RUN, 0, 0, 0, 0);
    set_graph(4, 0, 7);
    send_request(ACT_RUN, 0, 0, 0, 0);
    set_graph(0, 0, 1);
    send_request(ACT_RUN, 0, 0, 0, 0);
    send_request(ACT_READ, 0, 1, 0, 0);

    // Random phases over varied settings.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        3: n = 16;
        5: n = 31;
        7: n = 1;
        default: n = $urandom_range(3, 7);
      endcase
      if (ph == 8) set_graph(n, 15, 0);
      else set_graph(n, $urandom_range(0, nodes_now_of(n) - 1),
                     $urandom_range(0, nodes_now_of(n) - 1));
      calm = (ph == 4);
      if (ph == 6) begin
        hold_req = 1;
        repeat (30) send_request(ACT_READ, $urandom_range(0, 15), $urandom_range(0, 15), 0, 0);
      end
      random_phase((ph == 3 || ph == 5) ? 60 : 75);
      if (ph != 7) send_request(ACT_RUN, 0, 0, 0, 0);
      calm = 0;
    end

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("[min_cost_max_flow_engine] OK");
    end else begin
      $display("[min_cost_max_flow_engine] ERROR");
    end
    $finish;
  end
endmodule
